// File: hdl/active_expired_priority_queue_assert.svh
// Assertion macros for the active/expired priority queue.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef ACTIVE_EXPIRED_PRIORITY_QUEUE_ASSERT_SVH
`define ACTIVE_EXPIRED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define AEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/aeq_pkg.sv
// Shared types, constants and helpers of the active/expired priority queue.
// No dependencies; used by every module of the block.
package aeq_pkg;

	localparam int LEVELS      = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int PID_WIDTH   = 8;

	localparam int NQ      = 2 * LEVELS;
	localparam int QIDX_W  = $clog2(NQ);
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int TOTAL_W = $clog2(LEVELS * QUEUE_DEPTH + 1);
	localparam int ADDR_W  = QIDX_W + PTR_W;
	localparam int DEPTH   = NQ * QUEUE_DEPTH;

	// Fixed field widths
	localparam int LC_W   = 3;
	localparam int LVL_W  = 2;
	localparam int DYN_W  = 2;
	localparam int SP_W   = 3;
	localparam int STAT_W = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LC_W-1:0] LEVEL_COUNT_RESET = LC_W'(4);

	typedef enum logic [0:0] {
		ACT_ADD  = 1'b0,
		ACT_TAKE = 1'b1
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_LEVEL_COUNT = 1'b0
	} reg_idx_t;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [QIDX_W-1:0] qidx_t;

	typedef struct packed {
		action_t              action;
		logic [PID_WIDTH-1:0] pid;
		logic [DYN_W-1:0]     dyn_prio;
		logic [SP_W-1:0]      static_prio;
		logic                 preempted;
	} item_t;

	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [ADDR_W-1:0]    addr;
		logic [PID_WIDTH-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		status_t              status;
		logic [PID_WIDTH-1:0] pid;
		logic [LVL_W-1:0]     level;
		logic                 to_expired;
		logic                 from_mem;
	} result_t;

	function automatic ptr_t wrap_next(ptr_t p);
		int n;
		n = int'(p) + 1;
		return (n >= QUEUE_DEPTH) ? '0 : PTR_W'(n);
	endfunction

endpackage

// File: hdl/aeq_slot_ram.sv
// Slot storage for all level queues: one write or one read per cycle.
// Depends on aeq_pkg for the ram request type and sizes.
module aeq_slot_ram (
	input  logic                          clk,
	input  aeq_pkg::ram_req_t             req,
	output logic [aeq_pkg::PID_WIDTH-1:0] rdata
);

	logic [aeq_pkg::PID_WIDTH-1:0] mem [aeq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
	end

	// Hold read data unless a new read is issued
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// File: hdl/aeq_queue_ctrl.sv
// Queue bookkeeping: pointers, fill levels, bank select and totals.
// Depends on aeq_pkg; drives the slot RAM request and the item result.
module aeq_queue_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  aeq_pkg::item_t           item,
	input  logic [aeq_pkg::LC_W-1:0] level_count,
	output aeq_pkg::ram_req_t        ram_req,
	output aeq_pkg::result_t         res
);

	aeq_pkg::ptr_t                 head_q [aeq_pkg::NQ];
	aeq_pkg::ptr_t                 tail_q [aeq_pkg::NQ];
	logic [aeq_pkg::FILL_W-1:0]    fill_q [aeq_pkg::NQ];
	logic                          bank_q;
	logic [aeq_pkg::TOTAL_W-1:0]   act_total_q;
	logic [aeq_pkg::TOTAL_W-1:0]   exp_total_q;

	logic [aeq_pkg::LC_W-1:0]      lc_eff;
	logic [aeq_pkg::SP_W-1:0]      sp_c;
	logic [aeq_pkg::DYN_W-1:0]     dyn_m;
	logic [aeq_pkg::LVL_W-1:0]     add_lvl;
	logic                          add_exp;
	logic                          add_bank;
	aeq_pkg::qidx_t                add_q;
	logic                          add_full;
	logic                          swap;
	logic                          take_bank;
	logic                          found;
	aeq_pkg::qidx_t                take_q;
	logic [aeq_pkg::LVL_W-1:0]     take_lvl;
	logic [aeq_pkg::TOTAL_W-1:0]   act_eff;
	logic [aeq_pkg::TOTAL_W-1:0]   exp_eff;
	logic [aeq_pkg::TOTAL_W-1:0]   act_take;
	logic                          is_add;

	assign is_add = (item.action == aeq_pkg::ACT_ADD);

	always_comb begin
		if (level_count == '0) begin
			lc_eff = aeq_pkg::LC_W'(1);
		end else if (int'(level_count) > aeq_pkg::LEVELS) begin
			lc_eff = aeq_pkg::LC_W'(aeq_pkg::LEVELS);
		end else begin
			lc_eff = level_count;
		end
	end

	// Add path: clamp static priority, demote on preemption, pick queue
	always_comb begin
		sp_c = (item.static_prio == '0) ? aeq_pkg::SP_W'(1) : item.static_prio;
		if (sp_c > lc_eff) begin
			sp_c = lc_eff;
		end
		add_exp = item.preempted && (item.dyn_prio == '0);
		dyn_m   = item.dyn_prio - aeq_pkg::DYN_W'(item.preempted);
		if (add_exp) begin
			add_lvl  = aeq_pkg::LVL_W'(sp_c - aeq_pkg::SP_W'(1));
			add_bank = ~bank_q;
		end else begin
			if (aeq_pkg::LC_W'(dyn_m) >= lc_eff) begin
				add_lvl = aeq_pkg::LVL_W'(lc_eff - aeq_pkg::LC_W'(1));
			end else begin
				add_lvl = aeq_pkg::LVL_W'(dyn_m);
			end
			add_bank = bank_q;
		end
		add_q    = aeq_pkg::QIDX_W'(int'(add_bank) * aeq_pkg::LEVELS + int'(add_lvl));
		add_full = (int'(fill_q[add_q]) >= aeq_pkg::QUEUE_DEPTH);
	end

	// Take path: swap banks on an empty active side, find highest level
	always_comb begin
		swap      = (act_total_q == '0);
		take_bank = swap ? ~bank_q : bank_q;
		act_eff   = swap ? exp_total_q : act_total_q;
		exp_eff   = swap ? '0 : exp_total_q;
		found     = 1'b0;
		take_q    = '0;
		take_lvl  = '0;
		for (int i = 0; i < aeq_pkg::LEVELS; i++) begin
			if ((i < int'(lc_eff)) &&
			    (fill_q[aeq_pkg::QIDX_W'(int'(take_bank) * aeq_pkg::LEVELS + i)] != '0)) begin
				found    = 1'b1;
				take_q   = aeq_pkg::QIDX_W'(int'(take_bank) * aeq_pkg::LEVELS + i);
				take_lvl = aeq_pkg::LVL_W'(i);
			end
		end
		act_take = (found && (act_eff != '0)) ? act_eff - aeq_pkg::TOTAL_W'(1) : act_eff;
	end

	always_comb begin
		ram_req = '0;
		res     = '0;
		if (is_add) begin
			ram_req.we     = go && !add_full;
			ram_req.addr   = {add_q, tail_q[add_q]};
			ram_req.wdata  = item.pid;
			res.status     = add_full ? aeq_pkg::STATUS_FULL : aeq_pkg::STATUS_OK;
			res.pid        = item.pid;
			res.level      = add_lvl;
			res.to_expired = add_exp;
		end else begin
			ram_req.re   = go && found;
			ram_req.addr = {take_q, head_q[take_q]};
			res.status   = found ? aeq_pkg::STATUS_OK : aeq_pkg::STATUS_EMPTY;
			res.level    = found ? take_lvl : '0;
			res.from_mem = found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aeq_pkg::NQ; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			bank_q      <= 1'b0;
			act_total_q <= '0;
			exp_total_q <= '0;
		end else if (go) begin
			if (is_add) begin
				if (!add_full) begin
					tail_q[add_q] <= aeq_pkg::wrap_next(tail_q[add_q]);
					fill_q[add_q] <= fill_q[add_q] + aeq_pkg::FILL_W'(1);
					if (add_exp) begin
						exp_total_q <= exp_total_q + aeq_pkg::TOTAL_W'(1);
					end else begin
						act_total_q <= act_total_q + aeq_pkg::TOTAL_W'(1);
					end
				end
			end else begin
				bank_q      <= take_bank;
				exp_total_q <= exp_eff;
				act_total_q <= act_take;
				if (found) begin
					head_q[take_q] <= aeq_pkg::wrap_next(head_q[take_q]);
					fill_q[take_q] <= fill_q[take_q] - aeq_pkg::FILL_W'(1);
				end
			end
		end
	end

endmodule

// File: hdl/active_expired_priority_queue.sv
// Active/expired multilevel priority queue, top level.
// An accepted item is registered in stage 1, its result in the result stage; each item makes
// one access to the single-port slot RAM; one item per cycle unless the result output stalls.
// Reset clears all queue pointers, fill levels, totals, bank select and the
// pipeline valids, and sets level_count to 4; slot RAM contents stay as they are.
// Depends on aeq_pkg, aeq_queue_ctrl, aeq_slot_ram and the assertion macro header.
`include "active_expired_priority_queue_assert.svh"

module active_expired_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,

	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aeq_pkg::PADDR_W-1:0]       paddr,
	input  logic [aeq_pkg::PDATA_W-1:0]       pwdata,
	output logic [aeq_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,

	// input item channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [aeq_pkg::PID_WIDTH-1:0]     process_id,
	input  logic [aeq_pkg::DYN_W-1:0]         dyn_prio,
	input  logic [aeq_pkg::SP_W-1:0]          static_prio,
	input  logic                              was_preempted,

	// result item channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [aeq_pkg::STAT_W-1:0]        status,
	output logic [aeq_pkg::PID_WIDTH-1:0]     out_process_id,
	output logic [aeq_pkg::LVL_W-1:0]         level,
	output logic                              to_expired
);

	logic [aeq_pkg::LC_W-1:0]      level_count_q;
	logic                          cfg_wr;
	aeq_pkg::reg_idx_t             reg_sel;

	logic                          valid_s1;
	aeq_pkg::item_t                item_s1;
	logic                          valid_s2;
	aeq_pkg::result_t              res_s2;
	logic                          go;

	aeq_pkg::ram_req_t             ram_req;
	aeq_pkg::result_t              res;
	logic [aeq_pkg::PID_WIDTH-1:0] ram_rdata;

	// ---------------- configuration ----------------
	// Only one register; decode the word index from the address.
	assign pready  = 1'b1;
	assign reg_sel = aeq_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready &&
	                 (reg_sel == aeq_pkg::REG_LEVEL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= aeq_pkg::LEVEL_COUNT_RESET;
		end else if (cfg_wr) begin
			level_count_q <= pwdata[aeq_pkg::LC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			aeq_pkg::REG_LEVEL_COUNT: prdata = aeq_pkg::PDATA_W'(level_count_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// Stage 1 holds the accepted item; it advances into the result stage
	// whenever that stage is empty or its result is being taken. Queue
	// state and the slot RAM change only on that advance, so a stalled
	// result keeps its RAM read data.
	assign go        = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || go;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the item payload on accept
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action      <= aeq_pkg::action_t'(action);
			item_s1.pid         <= process_id;
			item_s1.dyn_prio    <= dyn_prio;
			item_s1.static_prio <= static_prio;
			item_s1.preempted   <= was_preempted;
		end
	end

	// Capture the result fields as the item leaves stage 1
	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= res;
		end
	end

	// ---------------- queue logic and storage ----------------
	aeq_queue_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.item        (item_s1),
		.level_count (level_count_q),
		.ram_req     (ram_req),
		.res         (res)
	);

	aeq_slot_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// ---------------- result outputs ----------------
	// A successful take gets its process id from the registered RAM read.
	assign status         = res_s2.status;
	assign out_process_id = res_s2.from_mem ? ram_rdata : res_s2.pid;
	assign level          = res_s2.level;
	assign to_expired     = res_s2.to_expired;

	// ---------------- assertions ----------------
	`AEQ_ASSERT_NOW(a_full_no_write, go && (res.status == aeq_pkg::STATUS_FULL), !ram_req.we, "full queue written")
	`AEQ_ASSERT_NOW(a_mem_ok, valid_s2 && res_s2.from_mem, res_s2.status == aeq_pkg::STATUS_OK, "bad take status")
	`AEQ_ASSERT_NOW(a_stall_cause, valid_s1 && !in_ready, valid_s2 && !out_ready, "stall without back pressure")
	`AEQ_ASSERT_NEXT(a_read_lands, ram_req.re, valid_s2 && res_s2.from_mem, "read without result")

endmodule
